// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies; the users provide clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NEXT(label, ante, cons)
`define ASSERT_SAME(label, ante, cons)
`endif
`endif

// ===== hw/rtl/tpm_pkg.sv =====
// types, constants and saturating helpers of the mobility evaluator
// no dependencies
package tpm_pkg;

    typedef logic signed [63:0] fix_t;

    localparam fix_t BIG     = fix_t'({1'b0, {63{1'b1}}});
    localparam fix_t NEG_BIG = fix_t'({1'b1, {62{1'b0}}, 1'b1});
    localparam fix_t Q16     = fix_t'(64'd65536);

    localparam int DIV_STEP = 2;
    localparam int NDIV     = 64 / DIV_STEP;
    localparam int MD_LAT   = NDIV + 4;

    localparam int OUT_W = 48;
    localparam fix_t OUT_MAX = fix_t'({17'd0, {47{1'b1}}});
    localparam fix_t OUT_MIN = fix_t'({{17{1'b1}}, {47{1'b0}}});

    localparam logic [2:0] CFG_LINEAR    = 3'd0;
    localparam logic [2:0] CFG_RES_OIL   = 3'd1;
    localparam logic [2:0] CFG_RES_WATER = 3'd2;
    localparam logic [2:0] CFG_VISC_OIL  = 3'd3;
    localparam logic [2:0] CFG_VISC_WAT  = 3'd4;
    localparam logic [2:0] CFG_CAP_SCALE = 3'd5;

    typedef struct packed {
        logic ovf;
        fix_t val;
    } sum_t;

    typedef struct packed {
        logic                    ovf;
        logic signed [OUT_W-1:0] val;
    } out_t;

    // one divider stage: partial remainder, dividend bits left, quotient so far
    typedef struct packed {
        logic [63:0] r;
        logic [63:0] lo;
        logic [63:0] q;
        logic [63:0] uc;
        logic        neg;
        logic        zero;
        logic        big;
        logic        zsign;
    } div_stage_t;

    function automatic logic [63:0] mag64(input fix_t x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    function automatic sum_t sat_add(input fix_t a, input fix_t b);
        logic signed [64:0] w;
        logic signed [64:0] hi;
        sum_t res;
        hi = {1'b0, BIG};
        w = {a[63], a} + {b[63], b};
        res.ovf = 1'b0;
        res.val = w[63:0];
        if (w > hi)
        begin
            res.ovf = 1'b1;
            res.val = BIG;
        end
        else if (w < -hi)
        begin
            res.ovf = 1'b1;
            res.val = NEG_BIG;
        end
        return res;
    endfunction

    function automatic sum_t sat_sub(input fix_t a, input fix_t b);
        return sat_add(a, -b);
    endfunction

    function automatic out_t out48(input fix_t x);
        out_t res;
        res.ovf = 1'b0;
        res.val = x[OUT_W-1:0];
        if (x > OUT_MAX)
        begin
            res.ovf = 1'b1;
            res.val = OUT_MAX[OUT_W-1:0];
        end
        else if (x < OUT_MIN)
        begin
            res.ovf = 1'b1;
            res.val = OUT_MIN[OUT_W-1:0];
        end
        return res;
    endfunction

    function automatic div_stage_t div_step(input div_stage_t d);
        div_stage_t n;
        n = d;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            n.r  = {n.r[62:0], n.lo[63]};
            n.lo = {n.lo[62:0], 1'b0};
            n.q  = {n.q[62:0], 1'b0};
            if (n.r >= n.uc)
            begin
                n.r    = n.r - n.uc;
                n.q[0] = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/tpm_muldiv.sv =====
// pipelined a*b/c unit, round to nearest, ties away, saturating
// depends on tpm_pkg
module tpm_muldiv
    import tpm_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  fix_t              a,
    input  fix_t              b,
    input  fix_t              c,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vld_out,
    output fix_t              q,
    output logic              flag,
    output logic [SIDE_W-1:0] side_out
);

    logic [63:0] ua, ub, uc;
    logic [63:0] p0, p1, p2, p3;
    logic [63:0] p0_reg, p1_reg, p2_reg, p3_reg, uc0_reg, uc1_reg;
    logic        nab0_reg, cneg0_reg, nab1_reg, cneg1_reg;
    logic [127:0] prod1_reg;
    div_stage_t  dv_init;
    div_stage_t  dv_reg [NDIV+1];
    div_stage_t  dl;
    logic [64:0] q65;
    logic        ovf;
    fix_t        res;
    logic        fl;
    fix_t        q_reg;
    logic        flag_reg;
    logic [SIDE_W-1:0] side_reg [MD_LAT];
    logic [MD_LAT-1:0] vld_reg;

    // 32x32 partial products
    always_comb
    begin
        ua = mag64(a);
        ub = mag64(b);
        uc = mag64(c);
        p0 = ua[31:0] * ub[31:0];
        p1 = ua[31:0] * ub[63:32];
        p2 = ua[63:32] * ub[31:0];
        p3 = ua[63:32] * ub[63:32];
    end

    always_comb
    begin
        dv_init.r     = prod1_reg[127:64];
        dv_init.lo    = prod1_reg[63:0];
        dv_init.q     = 64'd0;
        dv_init.uc    = uc1_reg;
        dv_init.neg   = nab1_reg ^ cneg1_reg;
        dv_init.zero  = (uc1_reg == 64'd0);
        dv_init.big   = (prod1_reg[127:64] >= uc1_reg);
        dv_init.zsign = nab1_reg && (prod1_reg != 128'd0);
    end

    always_comb
    begin
        dl  = dv_reg[NDIV];
        q65 = {1'b0, dl.q} + (((dl.r >= (dl.uc - dl.r))) ? 65'd1 : 65'd0);
        ovf = dl.big || (q65 > {2'b00, BIG[62:0]});
        if (dl.zero)
        begin
            res = dl.zsign ? NEG_BIG : BIG;
            fl  = 1'b1;
        end
        else if (ovf)
        begin
            res = dl.neg ? NEG_BIG : BIG;
            fl  = 1'b1;
        end
        else
        begin
            res = dl.neg ? -fix_t'(q65[63:0]) : fix_t'(q65[63:0]);
            fl  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg    <= p0;
            p1_reg    <= p1;
            p2_reg    <= p2;
            p3_reg    <= p3;
            uc0_reg   <= uc;
            nab0_reg  <= a[63] ^ b[63];
            cneg0_reg <= c[63];
            prod1_reg <= {64'd0, p0_reg} + {32'd0, p1_reg, 32'd0}
                       + {32'd0, p2_reg, 32'd0} + {p3_reg, 64'd0};
            uc1_reg   <= uc0_reg;
            nab1_reg  <= nab0_reg;
            cneg1_reg <= cneg0_reg;
            dv_reg[0] <= dv_init;
            for (int k = 1; k <= NDIV; k++)
            begin
                dv_reg[k] <= div_step(dv_reg[k-1]);
            end
            q_reg    <= res;
            flag_reg <= fl;
            side_reg[0] <= side_in;
            for (int i = 1; i < MD_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[MD_LAT-2:0], vld_in};
        end
    end

    assign q        = q_reg;
    assign flag     = flag_reg;
    assign vld_out  = vld_reg[MD_LAT-1];
    assign side_out = side_reg[MD_LAT-1];

endmodule

// ===== hw/rtl/two_phase_mobility_eval.sv =====
// two-phase mobility evaluator top level: config registers and pipeline
// depends on tpm_pkg, tpm_muldiv and assert_macros.svh
//
//   channel   signals                              direction
//   in        in_valid, in_stall, saturation       word in, stall out
//   out       out_valid, out_stall, five results,  word out, stall in
//             overflow
//   cfg       cfg_valid, cfg_ready, cfg_index,     register write in
//             cfg_data
//
// one word enters per cycle while in_stall is low; its result shows on the output
// after the word passes the entry register and six dependent a*b/c units in a row,
// each a 2-bit-per-stage restoring divider behind a staged 64x64 multiply, with
// one stage register after each unit
// reset clears the valid bits and loads the register defaults
// the whole pipeline holds only when the output word is stalled and a
// finished word sits in the last stage; otherwise bubbles are squeezed out
`include "assert_macros.svh"

module two_phase_mobility_eval
    import tpm_pkg::*;
#(
    parameter int SAT_FRAC_BITS = 30,
    parameter int OUT_FRAC_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [30:0]             saturation,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] total_mobility,
    output logic signed [OUT_W-1:0] oil_mob,
    output logic signed [OUT_W-1:0] water_mob,
    output logic signed [OUT_W-1:0] water_mob_slope,
    output logic signed [OUT_W-1:0] cap_slope,
    output logic                    overflow,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_data
);

    // saturation format to internal format
    localparam int LSH = (OUT_FRAC_BITS >= SAT_FRAC_BITS) ? OUT_FRAC_BITS - SAT_FRAC_BITS : 0;
    localparam int RSH = (SAT_FRAC_BITS > OUT_FRAC_BITS) ? SAT_FRAC_BITS - OUT_FRAC_BITS : 0;
    localparam logic [63:0] RND = (64'd1 << RSH) >> 1;

    localparam fix_t ONE     = fix_t'(64'd1 << OUT_FRAC_BITS);
    localparam fix_t TWO     = fix_t'(64'd1 << (OUT_FRAC_BITS + 1));
    localparam fix_t NEG_ONE = -ONE;
    localparam fix_t NEG_TWO = -TWO;

    function automatic fix_t to_fix(input logic [30:0] x);
        logic [63:0] w;
        w = {33'd0, x};
        if (OUT_FRAC_BITS >= SAT_FRAC_BITS)
        begin
            w = w << LSH;
        end
        else
        begin
            w = (w + RND) >> RSH;
        end
        return fix_t'(w);
    endfunction

    // ---------------- configuration registers ----------------
    logic        lin_reg;
    logic [29:0] ro_reg, rw_reg;
    logic [31:0] vo_reg, vw_reg, eta_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reg <= 1'b0;
            ro_reg  <= '0;
            rw_reg  <= '0;
            vo_reg  <= 32'd65536;
            vw_reg  <= 32'd65536;
            eta_reg <= 32'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LINEAR:    lin_reg <= cfg_data[0];
                CFG_RES_OIL:   ro_reg  <= cfg_data[29:0];
                CFG_RES_WATER: rw_reg  <= cfg_data[29:0];
                CFG_VISC_OIL:  vo_reg  <= cfg_data;
                CFG_VISC_WAT:  vw_reg  <= cfg_data;
                CFG_CAP_SCALE: eta_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- values that follow from the registers ----------------
    // these run free; the user must let them settle well before a word needs them
    fix_t ro_fix, rw_fix, vo_fix, vw_fix, eta_fix;
    sum_t dor_s, dw_s, g1_s, g_s;
    fix_t dor_reg, dw_reg, g_reg;
    logic cq_sub_reg, cc_sub_reg;
    fix_t dw2_q, zq_q, z_q, neta_q;
    logic dw2_f, zq_f, z_f, neta_f;

    always_comb
    begin
        ro_fix  = to_fix({1'b0, ro_reg});
        rw_fix  = to_fix({1'b0, rw_reg});
        vo_fix  = fix_t'({32'd0, vo_reg});
        vw_fix  = fix_t'({32'd0, vw_reg});
        eta_fix = fix_t'({32'd0, eta_reg});
        dor_s   = sat_sub(ONE, ro_fix);
        dw_s    = sat_sub(ONE, rw_fix);
        g1_s    = sat_sub(ONE, ro_fix);
        g_s     = sat_sub(g1_s.val, rw_fix);
    end

    always_ff @(posedge clk)
    begin
        dor_reg    <= dor_s.val;
        dw_reg     <= dw_s.val;
        g_reg      <= g_s.val;
        cq_sub_reg <= dor_s.ovf | dw_s.ovf;
        cc_sub_reg <= g1_s.ovf | g_s.ovf;
    end

    // dw^2, ro/g, (ro/g)^2, -2 eta
    tpm_muldiv u_dw2 (.clk, .rst_n, .en(1'b1), .vld_in(1'b0), .a(dw_reg), .b(dw_reg),
        .c(ONE), .side_in(1'b0), .vld_out(), .q(dw2_q), .flag(dw2_f), .side_out());
    tpm_muldiv u_zq (.clk, .rst_n, .en(1'b1), .vld_in(1'b0), .a(ro_fix), .b(ONE),
        .c(g_reg), .side_in(1'b0), .vld_out(), .q(zq_q), .flag(zq_f), .side_out());
    tpm_muldiv u_z (.clk, .rst_n, .en(1'b1), .vld_in(1'b0), .a(zq_q), .b(zq_q),
        .c(ONE), .side_in(1'b0), .vld_out(), .q(z_q), .flag(z_f), .side_out());
    tpm_muldiv u_neta (.clk, .rst_n, .en(1'b1), .vld_in(1'b0), .a(eta_fix), .b(NEG_TWO),
        .c(Q16), .side_in(1'b0), .vld_out(), .q(neta_q), .flag(neta_f), .side_out());

    logic cfg_flag_q, cfg_flag_c;
    assign cfg_flag_q = cq_sub_reg | dw2_f;
    assign cfg_flag_c = cc_sub_reg | zq_f | z_f | neta_f;

    // ---------------- pipeline control ----------------
    logic advance;
    logic v6;
    logic out_valid_reg;

    // hold only when a finished word cannot move into the output register
    assign advance  = !(out_valid_reg && out_stall && v6);
    assign in_stall = !advance;

    // ---------------- stage 0: entry ----------------
    fix_t s_in;
    sum_t e_s, f_s;
    logic v0_reg, fc0_reg;
    fix_t s0_reg, e0_reg, f0_reg;

    always_comb
    begin
        s_in = to_fix(saturation);
        e_s  = sat_sub(s_in, rw_fix);
        f_s  = sat_sub(ONE, s_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg  <= s_in;
            e0_reg  <= e_s.val;
            f0_reg  <= f_s.val;
            fc0_reg <= e_s.ovf | f_s.ovf;
        end
    end

    // ---------------- level 1: s/dor, 1/e, 1/(1-s) ----------------
    logic v0_d, fc0_d;
    fix_t s0_d, e0_d, f0_d;
    fix_t u_q, ie_q, if_q;
    logic u_f, ie_f, if_f;

    tpm_muldiv #(.SIDE_W(193)) u_l1_u (.clk, .rst_n, .en(advance), .vld_in(v0_reg),
        .a(s0_reg), .b(ONE), .c(dor_reg), .side_in({fc0_reg, s0_reg, e0_reg, f0_reg}),
        .vld_out(v0_d), .q(u_q), .flag(u_f), .side_out({fc0_d, s0_d, e0_d, f0_d}));
    tpm_muldiv u_l1_ie (.clk, .rst_n, .en(advance), .vld_in(v0_reg), .a(ONE), .b(ONE),
        .c(e0_reg), .side_in(1'b0), .vld_out(), .q(ie_q), .flag(ie_f), .side_out());
    tpm_muldiv u_l1_if (.clk, .rst_n, .en(advance), .vld_in(v0_reg), .a(ONE), .b(ONE),
        .c(f0_reg), .side_in(1'b0), .vld_out(), .q(if_q), .flag(if_f), .side_out());

    sum_t t_s;
    logic v1_reg, fq1_reg, fc1_reg;
    fix_t t1_reg, e1_reg, s1_reg, f1_reg, ie1_reg, if1_reg;

    assign t_s = sat_sub(ONE, u_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= v0_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t1_reg  <= t_s.val;
            e1_reg  <= e0_d;
            s1_reg  <= s0_d;
            f1_reg  <= f0_d;
            ie1_reg <= ie_q;
            if1_reg <= if_q;
            fq1_reg <= u_f | t_s.ovf;
            fc1_reg <= fc0_d | ie_f | if_f;
        end
    end

    // ---------------- level 2: quadratic curves, squares of inverses ----------------
    logic v1_d, fq1_d, fc1_d;
    fix_t s1_d, f1_d, ie1_d, if1_d;
    fix_t kro_q, dkro_q, krw_q, dkrw_q, sqe_q, sqf_q;
    logic kro_f, dkro_f, krw_f, dkrw_f, sqe_f, sqf_f;

    tpm_muldiv #(.SIDE_W(258)) u_l2_kro (.clk, .rst_n, .en(advance), .vld_in(v1_reg),
        .a(t1_reg), .b(t1_reg), .c(ONE),
        .side_in({fq1_reg, fc1_reg, s1_reg, f1_reg, ie1_reg, if1_reg}),
        .vld_out(v1_d), .q(kro_q), .flag(kro_f),
        .side_out({fq1_d, fc1_d, s1_d, f1_d, ie1_d, if1_d}));
    tpm_muldiv u_l2_dkro (.clk, .rst_n, .en(advance), .vld_in(v1_reg), .a(t1_reg),
        .b(NEG_TWO), .c(dor_reg), .side_in(1'b0), .vld_out(), .q(dkro_q), .flag(dkro_f),
        .side_out());
    tpm_muldiv u_l2_krw (.clk, .rst_n, .en(advance), .vld_in(v1_reg), .a(e1_reg),
        .b(e1_reg), .c(dw2_q), .side_in(1'b0), .vld_out(), .q(krw_q), .flag(krw_f),
        .side_out());
    tpm_muldiv u_l2_dkrw (.clk, .rst_n, .en(advance), .vld_in(v1_reg), .a(e1_reg),
        .b(TWO), .c(dw2_q), .side_in(1'b0), .vld_out(), .q(dkrw_q), .flag(dkrw_f),
        .side_out());
    tpm_muldiv u_l2_sqe (.clk, .rst_n, .en(advance), .vld_in(v1_reg), .a(ie1_reg),
        .b(ie1_reg), .c(ONE), .side_in(1'b0), .vld_out(), .q(sqe_q), .flag(sqe_f),
        .side_out());
    tpm_muldiv u_l2_sqf (.clk, .rst_n, .en(advance), .vld_in(v1_reg), .a(if1_reg),
        .b(if1_reg), .c(ONE), .side_in(1'b0), .vld_out(), .q(sqf_q), .flag(sqf_f),
        .side_out());

    logic v2_reg, fl2_reg;
    fix_t kro2_reg, dkro2_reg, krw2_reg, dkrw2_reg, sqe2_reg, sqf2_reg, ie2_reg, if2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v2_reg <= v1_d;
        end
    end

    // linear mode replaces the curves; the quadratic flags then do not count
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kro2_reg  <= lin_reg ? f1_d : kro_q;
            dkro2_reg <= lin_reg ? NEG_ONE : dkro_q;
            krw2_reg  <= lin_reg ? s1_d : krw_q;
            dkrw2_reg <= lin_reg ? ONE : dkrw_q;
            sqe2_reg  <= sqe_q;
            sqf2_reg  <= sqf_q;
            ie2_reg   <= ie1_d;
            if2_reg   <= if1_d;
            fl2_reg   <= fc1_d | sqe_f | sqf_f
                       | (!lin_reg & (fq1_d | kro_f | dkro_f | krw_f | dkrw_f));
        end
    end

    // ---------------- level 3: phase mobilities, cubes of inverses ----------------
    logic v2_d, fl2_d;
    fix_t mo_q, mw_q, dmo_q, dmw_q, cube_q, cubf_q;
    logic mo_f, mw_f, dmo_f, dmw_f, cube_f, cubf_f;

    tpm_muldiv u_l3_mo (.clk, .rst_n, .en(advance), .vld_in(v2_reg), .a(kro2_reg),
        .b(Q16), .c(vo_fix), .side_in(fl2_reg), .vld_out(v2_d), .q(mo_q), .flag(mo_f),
        .side_out(fl2_d));
    tpm_muldiv u_l3_mw (.clk, .rst_n, .en(advance), .vld_in(v2_reg), .a(krw2_reg),
        .b(Q16), .c(vw_fix), .side_in(1'b0), .vld_out(), .q(mw_q), .flag(mw_f),
        .side_out());
    tpm_muldiv u_l3_dmo (.clk, .rst_n, .en(advance), .vld_in(v2_reg), .a(dkro2_reg),
        .b(Q16), .c(vo_fix), .side_in(1'b0), .vld_out(), .q(dmo_q), .flag(dmo_f),
        .side_out());
    tpm_muldiv u_l3_dmw (.clk, .rst_n, .en(advance), .vld_in(v2_reg), .a(dkrw2_reg),
        .b(Q16), .c(vw_fix), .side_in(1'b0), .vld_out(), .q(dmw_q), .flag(dmw_f),
        .side_out());
    tpm_muldiv u_l3_cube (.clk, .rst_n, .en(advance), .vld_in(v2_reg), .a(sqe2_reg),
        .b(ie2_reg), .c(ONE), .side_in(1'b0), .vld_out(), .q(cube_q), .flag(cube_f),
        .side_out());
    tpm_muldiv u_l3_cubf (.clk, .rst_n, .en(advance), .vld_in(v2_reg), .a(sqf2_reg),
        .b(if2_reg), .c(ONE), .side_in(1'b0), .vld_out(), .q(cubf_q), .flag(cubf_f),
        .side_out());

    sum_t tot_s, dtot_s;
    logic v3_reg, fl3_reg;
    fix_t mo3_reg, mw3_reg, tot3_reg, dtot3_reg, dmw3_reg, cube3_reg, cubf3_reg;

    assign tot_s  = sat_add(mo_q, mw_q);
    assign dtot_s = sat_add(dmo_q, dmw_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v3_reg <= v2_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mo3_reg   <= mo_q;
            mw3_reg   <= mw_q;
            tot3_reg  <= tot_s.val;
            dtot3_reg <= dtot_s.val;
            dmw3_reg  <= dmw_q;
            cube3_reg <= cube_q;
            cubf3_reg <= cubf_q;
            fl3_reg   <= fl2_d | mo_f | mw_f | dmo_f | dmw_f | cube_f | cubf_f
                       | tot_s.ovf | dtot_s.ovf;
        end
    end

    // ---------------- level 4: fractions, capillary second term ----------------
    logic v3_d, fl3_d;
    fix_t tot3_d, dtot3_d, dmw3_d, cube3_d;
    fix_t oil_q, wat_q, zt_q;
    logic oil_f, wat_f, zt_f;

    tpm_muldiv #(.SIDE_W(257)) u_l4_oil (.clk, .rst_n, .en(advance), .vld_in(v3_reg),
        .a(mo3_reg), .b(ONE), .c(tot3_reg),
        .side_in({fl3_reg, tot3_reg, dtot3_reg, dmw3_reg, cube3_reg}),
        .vld_out(v3_d), .q(oil_q), .flag(oil_f),
        .side_out({fl3_d, tot3_d, dtot3_d, dmw3_d, cube3_d}));
    tpm_muldiv u_l4_wat (.clk, .rst_n, .en(advance), .vld_in(v3_reg), .a(mw3_reg),
        .b(ONE), .c(tot3_reg), .side_in(1'b0), .vld_out(), .q(wat_q), .flag(wat_f),
        .side_out());
    tpm_muldiv u_l4_zt (.clk, .rst_n, .en(advance), .vld_in(v3_reg), .a(z_q),
        .b(cubf3_reg), .c(ONE), .side_in(1'b0), .vld_out(), .q(zt_q), .flag(zt_f),
        .side_out());

    sum_t sum_s;
    logic v4_reg, fl4_reg;
    fix_t oil4_reg, wat4_reg, sum4_reg, tot4_reg, dtot4_reg, dmw4_reg;

    assign sum_s = sat_add(cube3_d, zt_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v4_reg <= v3_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            oil4_reg  <= oil_q;
            wat4_reg  <= wat_q;
            sum4_reg  <= sum_s.val;
            tot4_reg  <= tot3_d;
            dtot4_reg <= dtot3_d;
            dmw4_reg  <= dmw3_d;
            fl4_reg   <= fl3_d | oil_f | wat_f | zt_f | sum_s.ovf;
        end
    end

    // ---------------- level 5: water * total', capillary slope ----------------
    logic v4_d, fl4_d;
    fix_t tot4_d, oil4_d, wat4_d, dmw4_d;
    fix_t wd_q, cap_q;
    logic wd_f, cap_f;

    tpm_muldiv #(.SIDE_W(257)) u_l5_wd (.clk, .rst_n, .en(advance), .vld_in(v4_reg),
        .a(wat4_reg), .b(dtot4_reg), .c(ONE),
        .side_in({fl4_reg, tot4_reg, oil4_reg, wat4_reg, dmw4_reg}),
        .vld_out(v4_d), .q(wd_q), .flag(wd_f),
        .side_out({fl4_d, tot4_d, oil4_d, wat4_d, dmw4_d}));
    tpm_muldiv u_l5_cap (.clk, .rst_n, .en(advance), .vld_in(v4_reg), .a(sum4_reg),
        .b(neta_q), .c(ONE), .side_in(1'b0), .vld_out(), .q(cap_q), .flag(cap_f),
        .side_out());

    sum_t diff_s;
    logic v5_reg, fl5_reg;
    fix_t diff5_reg, tot5_reg, oil5_reg, wat5_reg, cap5_reg;

    assign diff_s = sat_sub(dmw4_d, wd_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (advance)
        begin
            v5_reg <= v4_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            diff5_reg <= diff_s.val;
            tot5_reg  <= tot4_d;
            oil5_reg  <= oil4_d;
            wat5_reg  <= wat4_d;
            cap5_reg  <= cap_q;
            fl5_reg   <= fl4_d | wd_f | cap_f | diff_s.ovf;
        end
    end

    // ---------------- level 6: slope of the water fraction ----------------
    logic fl5_d;
    fix_t tot5_d, oil5_d, wat5_d, cap5_d;
    fix_t slope_q;
    logic slope_f;

    tpm_muldiv #(.SIDE_W(257)) u_l6_slope (.clk, .rst_n, .en(advance), .vld_in(v5_reg),
        .a(diff5_reg), .b(ONE), .c(tot5_reg),
        .side_in({fl5_reg, tot5_reg, oil5_reg, wat5_reg, cap5_reg}),
        .vld_out(v6), .q(slope_q), .flag(slope_f),
        .side_out({fl5_d, tot5_d, oil5_d, wat5_d, cap5_d}));

    // ---------------- output register ----------------
    out_t o_tot, o_oil, o_wat, o_slope, o_cap;
    logic flag_all;
    logic signed [OUT_W-1:0] tot_reg, oil_reg, wat_reg, slope_reg, cap_reg;
    logic ovf_reg;

    always_comb
    begin
        o_tot    = out48(tot5_d);
        o_oil    = out48(oil5_d);
        o_wat    = out48(wat5_d);
        o_slope  = out48(slope_q);
        o_cap    = out48(cap5_d);
        flag_all = fl5_d | slope_f | cfg_flag_c | (!lin_reg & cfg_flag_q)
                 | o_tot.ovf | o_oil.ovf | o_wat.ovf | o_slope.ovf | o_cap.ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= v6;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((!out_valid_reg || !out_stall) && v6)
        begin
            tot_reg   <= o_tot.val;
            oil_reg   <= o_oil.val;
            wat_reg   <= o_wat.val;
            slope_reg <= o_slope.val;
            cap_reg   <= o_cap.val;
            ovf_reg   <= flag_all;
        end
    end

    assign out_valid       = out_valid_reg;
    assign total_mobility  = tot_reg;
    assign oil_mob         = oil_reg;
    assign water_mob       = wat_reg;
    assign water_mob_slope = slope_reg;
    assign cap_slope       = cap_reg;
    assign overflow        = ovf_reg;

    // ---------------- checks ----------------
    // a word that leaves the pipeline while it moves lands in the output register
    `ASSERT_NEXT(a_last_lands, advance && v6, out_valid)
    // an accepted word shows up in the entry stage
    `ASSERT_NEXT(a_entry_loads, in_valid && !in_stall, v0_reg)
    // input only stalls while the downstream side stalls
    `ASSERT_SAME(a_stall_cause, in_stall, out_stall && out_valid)

endmodule

// ===== test/mobility_checker.sv =====
`timescale 1ns / 100ps
// result checker of the mobility evaluator: tracks register writes, predicts every word
// depends on tpm_pkg for the fixed-point type, saturation limits and register indexes
module mobility_checker
    import tpm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [30:0]             saturation,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [OUT_W-1:0] total_mobility,
    input  logic signed [OUT_W-1:0] oil_mob,
    input  logic signed [OUT_W-1:0] water_mob,
    input  logic signed [OUT_W-1:0] water_mob_slope,
    input  logic signed [OUT_W-1:0] cap_slope,
    input  logic                    overflow,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    output int                      fail_count,
    output int                      pending
);

    localparam fix_t ONE     = fix_t'(64'd1) <<< 32;
    localparam fix_t SAT_ONE = fix_t'(64'd1) <<< 30;
    localparam fix_t NEG_TWO = -(ONE <<< 1);

    typedef struct packed {
        logic signed [OUT_W-1:0] tot;
        logic signed [OUT_W-1:0] oil;
        logic signed [OUT_W-1:0] wat;
        logic signed [OUT_W-1:0] slope;
        logic signed [OUT_W-1:0] cap;
        logic                    ovf;
    } mob_word_t;

    logic        lin_mode;
    logic [29:0] res_oil;
    logic [29:0] res_wat;
    logic [31:0] visc_oil;
    logic [31:0] visc_wat;
    logic [31:0] cap_eta;

    bit          step_ovf;
    mob_word_t   expected_words[$];

    function automatic logic [63:0] abs64(fix_t x);
        return x[63] ? -x : x;
    endfunction

    // a*b/c, nearest with ties away from zero, saturated to +-BIG
    function automatic fix_t muldiv(fix_t a, fix_t b, fix_t c);
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rem;
        logic [127:0] den;
        bit neg;
        neg = a[63] != b[63];
        den = {64'd0, abs64(c)};
        if (den == 0)
        begin
            step_ovf = 1'b1;
            return (neg && a != 0 && b != 0) ? NEG_BIG : BIG;
        end
        if (c[63])
            neg = !neg;
        prod = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        quo = prod / den;
        rem = prod % den;
        if (rem >= den - rem)
            quo = quo + 1;
        if (quo > {64'd0, BIG})
        begin
            step_ovf = 1'b1;
            return neg ? NEG_BIG : BIG;
        end
        return neg ? -fix_t'(quo[63:0]) : fix_t'(quo[63:0]);
    endfunction

    function automatic fix_t sat_sum(fix_t a, fix_t b);
        if (b > 0 && a > BIG - b)
        begin
            step_ovf = 1'b1;
            return BIG;
        end
        if (b < 0 && a < NEG_BIG - b)
        begin
            step_ovf = 1'b1;
            return NEG_BIG;
        end
        return a + b;
    endfunction

    function automatic fix_t sat_diff(fix_t a, fix_t b);
        return sat_sum(a, -b);
    endfunction

    function automatic logic signed [OUT_W-1:0] clip48(fix_t v);
        if (v > OUT_MAX)
        begin
            step_ovf = 1'b1;
            v = OUT_MAX;
        end
        else if (v < OUT_MIN)
        begin
            step_ovf = 1'b1;
            v = OUT_MIN;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic fix_t inv_cube(fix_t x);
        fix_t inv;
        inv = muldiv(ONE, ONE, x);
        return muldiv(muldiv(inv, inv, ONE), inv, ONE);
    endfunction

    function automatic mob_word_t predict_mobility(logic [30:0] sat);
        fix_t s, ro, rw, e, vo, vw, kro, dkro, krw, dkrw, dor, dw, dw2, t;
        fix_t mo, mw, tot, dtot, wat, g, z, ssum, neta;
        mob_word_t w;
        step_ovf = 1'b0;
        vo = fix_t'({32'd0, visc_oil});
        vw = fix_t'({32'd0, visc_wat});
        s  = muldiv(fix_t'({33'd0, sat}), ONE, SAT_ONE);
        ro = muldiv(fix_t'({34'd0, res_oil}), ONE, SAT_ONE);
        rw = muldiv(fix_t'({34'd0, res_wat}), ONE, SAT_ONE);
        e  = sat_diff(s, rw);
        if (lin_mode)
        begin
            kro  = sat_diff(ONE, s);
            dkro = -ONE;
            krw  = s;
            dkrw = ONE;
        end
        else
        begin
            dor  = sat_diff(ONE, ro);
            dw   = sat_diff(ONE, rw);
            dw2  = muldiv(dw, dw, ONE);
            t    = sat_diff(ONE, muldiv(s, ONE, dor));
            kro  = muldiv(t, t, ONE);
            dkro = muldiv(t, NEG_TWO, dor);
            krw  = muldiv(e, e, dw2);
            dkrw = muldiv(e, -NEG_TWO, dw2);
        end
        mo   = muldiv(kro, Q16, vo);
        mw   = muldiv(krw, Q16, vw);
        tot  = sat_sum(mo, mw);
        dtot = sat_sum(muldiv(dkro, Q16, vo), muldiv(dkrw, Q16, vw));
        wat  = muldiv(mw, ONE, tot);
        w.tot   = clip48(tot);
        w.oil   = clip48(muldiv(mo, ONE, tot));
        w.wat   = clip48(wat);
        w.slope = clip48(muldiv(sat_diff(muldiv(dkrw, Q16, vw), muldiv(wat, dtot, ONE)),
                                ONE, tot));
        // capillary term is evaluated in both modes
        g    = sat_diff(sat_diff(ONE, ro), rw);
        z    = muldiv(ro, ONE, g);
        z    = muldiv(z, z, ONE);
        ssum = sat_sum(inv_cube(e), muldiv(z, inv_cube(sat_diff(ONE, s)), ONE));
        neta = muldiv(fix_t'({32'd0, cap_eta}), NEG_TWO, Q16);
        w.cap = clip48(muldiv(ssum, neta, ONE));
        w.ovf = step_ovf;
        return w;
    endfunction

    assign pending = expected_words.size();

    always @(posedge clk or negedge rst_n)
    begin
        mob_word_t got;
        mob_word_t want;
        if (!rst_n)
        begin
            lin_mode   <= 1'b0;
            res_oil    <= '0;
            res_wat    <= '0;
            visc_oil   <= 32'd65536;
            visc_wat   <= 32'd65536;
            cap_eta    <= 32'd65536;
            fail_count <= 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LINEAR:    lin_mode <= cfg_data[0];
                    CFG_RES_OIL:   res_oil  <= cfg_data[29:0];
                    CFG_RES_WATER: res_wat  <= cfg_data[29:0];
                    CFG_VISC_OIL:  visc_oil <= cfg_data;
                    CFG_VISC_WAT:  visc_wat <= cfg_data;
                    CFG_CAP_SCALE: cap_eta  <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_words.push_back(predict_mobility(saturation));
            if (out_valid && !out_stall)
            begin
                got = '{total_mobility, oil_mob, water_mob, water_mob_slope, cap_slope,
                        overflow};
                if (expected_words.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result word %p", got);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                        begin
                            $display("mismatch at %0t", $realtime);
                            if (got.tot !== want.tot)
                                $display("  total_mobility exp %h got %h",
                                         want.tot, got.tot);
                            if (got.oil !== want.oil)
                                $display("  oil_mob exp %h got %h", want.oil, got.oil);
                            if (got.wat !== want.wat)
                                $display("  water_mob exp %h got %h", want.wat, got.wat);
                            if (got.slope !== want.slope)
                                $display("  water_mob_slope exp %h got %h",
                                         want.slope, got.slope);
                            if (got.cap !== want.cap)
                                $display("  cap_slope exp %h got %h", want.cap, got.cap);
                            if (got.ovf !== want.ovf)
                                $display("  overflow exp %b got %b", want.ovf, got.ovf);
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== test/two_phase_mobility_eval_tb.sv =====
`timescale 1ns / 100ps
// testbench top of the mobility evaluator: clock, reset, stimulus and verdict
// depends on tpm_pkg, two_phase_mobility_eval and mobility_checker
module two_phase_mobility_eval_tb
    import tpm_pkg::*;
();

    localparam logic [30:0] SAT_ONE   = 31'h4000_0000;
    localparam logic [31:0] VISC_UNIT = 32'd65536;
    // pipeline depth of the block plus margin
    localparam int DRAIN_CYCLES = 260;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [30:0]             saturation;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [OUT_W-1:0] total_mobility;
    logic signed [OUT_W-1:0] oil_mob;
    logic signed [OUT_W-1:0] water_mob;
    logic signed [OUT_W-1:0] water_mob_slope;
    logic signed [OUT_W-1:0] cap_slope;
    logic                    overflow;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [2:0]              cfg_index;
    logic [31:0]             cfg_data;
    int                      fail_count;
    int                      pending;

    // stimulus shaping; the gap and hold flags are shared with the receiver process
    bit          no_gaps;
    bit          hold_request;
    logic [29:0] cur_res_wat;

    two_phase_mobility_eval dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .saturation      (saturation),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .total_mobility  (total_mobility),
        .oil_mob         (oil_mob),
        .water_mob       (water_mob),
        .water_mob_slope (water_mob_slope),
        .cap_slope       (cap_slope),
        .overflow        (overflow),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    mobility_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .saturation      (saturation),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .total_mobility  (total_mobility),
        .oil_mob         (oil_mob),
        .water_mob       (water_mob),
        .water_mob_slope (water_mob_slope),
        .cap_slope       (cap_slope),
        .overflow        (overflow),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, or one long hold-off on request to fill the pipeline
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (600) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (no_gaps)
                out_stall <= 1'b0;
            else
                out_stall <= (pick_gap() != 0);
        end
    end

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic put_word(input logic [30:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        saturation <= value;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // registers change only with the pipeline empty
    task automatic wait_drained();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_setting(input logic lin, input logic [29:0] ro, input logic [29:0] rw,
                                input logic [31:0] vo, input logic [31:0] vw,
                                input logic [31:0] eta);
        wait_drained();
        write_reg(CFG_LINEAR, {31'd0, lin});
        write_reg(CFG_RES_OIL, {2'd0, ro});
        write_reg(CFG_RES_WATER, {2'd0, rw});
        write_reg(CFG_VISC_OIL, vo);
        write_reg(CFG_VISC_WAT, vw);
        write_reg(CFG_CAP_SCALE, eta);
        cur_res_wat = rw;
    endtask

    function automatic logic [29:0] pick_residual();
        case ($urandom_range(0, 5))
            0: return 30'd0;
            1: return 30'h3FFF_FFFF;
            2: return 30'($urandom_range(0, 32'h0FFF_FFFF));
            default: return 30'($urandom_range(0, 32'h1333_3333));
        endcase
    endfunction

    function automatic logic [31:0] pick_visc();
        case ($urandom_range(0, 5))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2: return VISC_UNIT;
            default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_eta();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // well-formed saturations dominate; poles, endpoints and out-of-range values mixed in
    function automatic logic [30:0] pick_saturation();
        int r;
        r = $urandom_range(0, 99);
        if (r < 68)
            return 31'($urandom_range(0, 32'h4000_0000));
        if (r < 78)
            return 31'({1'b0, cur_res_wat}) + 31'($urandom_range(0, 2));
        if (r < 84)
            return ($urandom_range(0, 1) != 0) ? SAT_ONE : 31'd0;
        return 31'($urandom());
    endfunction

    initial
    begin
        logic [30:0] directed[$];
        int          n_items;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        saturation   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_LINEAR;
        cfg_data     = '0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        cur_res_wat  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset defaults: zero, one, the pole at zero, values past one, all ones
        directed = '{31'd0, 31'd1, 31'h2000_0000, 31'h3FFF_FFFF, SAT_ONE, 31'h4000_0001,
                     31'h7FFF_FFFF, 31'h5555_5555, 31'h0AAA_AAAA};
        foreach (directed[i])
            put_word(directed[i]);

        // linear curves, saturation at the residual water pole and at one
        load_setting(1'b1, 30'h0666_6666, 30'h0CCC_CCCD, VISC_UNIT, 32'h0000_8000, 32'd0);
        directed = '{31'd0, 31'h0CCC_CCCD, 31'h2000_0000, SAT_ONE, 31'h7FFF_FFFF};
        foreach (directed[i])
            put_word(directed[i]);

        // residuals summing to one: the capillary divisor is zero
        load_setting(1'b0, 30'h2000_0000, 30'h2000_0000, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed = '{31'd0, 31'h2000_0000, 31'h1000_0000, SAT_ONE, 31'h6000_0000};
        foreach (directed[i])
            put_word(directed[i]);

        // maximum residuals, maximum oil viscosity and minimum water viscosity
        load_setting(1'b0, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 32'd1, VISC_UNIT);
        directed = '{31'd0, 31'h3FFF_FFFF, SAT_ONE, 31'h1234_5678};
        foreach (directed[i])
            put_word(directed[i]);

        // random settings; phase 3 fills the pipeline, phase 6 pauses until drained
        for (int phase = 0; phase < 12; phase++)
        begin
            load_setting(1'(phase % 2), pick_residual(), pick_residual(), pick_visc(),
                         pick_visc(), pick_eta());
            no_gaps = (phase % 4 == 1) || (phase == 3);
            if (phase == 3)
                hold_request = 1'b1;
            n_items = (phase == 3) ? 300 : 115;
            for (int k = 0; k < n_items; k++)
            begin
                if (phase == 6 && k == n_items / 2)
                begin
                    in_valid <= 1'b0;
                    wait (pending == 0);
                    @(negedge clk);
                end
                put_word(pick_saturation());
            end
        end
        in_valid <= 1'b0;
        no_gaps = 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
